@@ rtl/crc16pf_pkg.sv @@
// Package for the CRC-16 packet framer.
// Holds the register indexes, the CRC constants and the byte-wise CRC update.
// Depends on nothing.
package crc16pf_pkg;

	localparam int unsigned CfgIndexWidth = 2;
	localparam int unsigned CfgDataWidth  = 16;

	typedef enum logic [CfgIndexWidth-1:0] {
		REG_MAGIC_FIRST    = 2'd0,
		REG_MAGIC_SECOND   = 2'd1,
		REG_PACKET_TYPE    = 2'd2,
		REG_PAYLOAD_LENGTH = 2'd3
	} cfg_reg_t;

	localparam logic [15:0] CrcPoly        = 16'hA001;
	localparam logic [15:0] CrcInit        = 16'hFFFF;
	localparam logic [15:0] LengthReset    = 16'd46080;
	localparam logic [15:0] LengthMinimum  = 16'd2;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/crc16_packet_framer_unit.sv @@
// Top level of the CRC-16 packet framer: input register, byte sequencer and output register.
// Uses crc16pf_pkg for register indexes, CRC constants and the CRC byte update.
// Result bytes leave one per cycle while out_stall is low; each passes the input and then the output register.
// A payload byte that opens a packet emits the five header bytes and its data byte, one that
// closes it emits its data byte and the two CRC bytes, any other emits only its data byte.
// A new input transaction is taken in the cycle its predecessor emits its last result byte.
// Reset clears the registers and the packet position, sets the running CRC to FFFF; length resets to 46080.
module crc16_packet_framer_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [crc16pf_pkg::CfgIndexWidth-1:0] cfg_index,
	input  logic [crc16pf_pkg::CfgDataWidth-1:0]  cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [7:0]                            payload_byte,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [7:0]                            out_byte,
	output logic                                  run_last,
	output logic                                  packet_end
);

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_HDR2,
		PH_HDR3,
		PH_HDR4,
		PH_DATA,
		PH_CRC_LO,
		PH_CRC_HI
	} phase_t;

	logic [7:0]  magic_first_q;
	logic [7:0]  magic_second_q;
	logic [7:0]  packet_type_q;
	logic [15:0] payload_length_q;

	logic        valid_s1;
	logic [7:0]  data_s1;

	phase_t      phase_q;
	logic [15:0] count_q;
	logic [15:0] crc_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        run_last_q;
	logic        packet_end_q;

	logic        advance;
	logic        emit;
	logic        done;
	logic [7:0]  emit_byte;
	logic        emit_end;
	logic [15:0] crc_next;
	logic [15:0] count_next;
	phase_t      phase_next;
	logic [15:0] len_eff;
	logic [16:0] count_inc;
	logic        in_take;

	always_comb begin
		len_eff   = (payload_length_q < crc16pf_pkg::LengthMinimum) ?
			crc16pf_pkg::LengthMinimum : payload_length_q;
		count_inc = {1'b0, count_q} + 17'd1;
		advance   = !out_valid_q || !out_stall;
		emit      = valid_s1 && advance;

		emit_byte  = data_s1;
		emit_end   = 1'b0;
		done       = 1'b0;
		crc_next   = crc_q;
		count_next = count_q;
		phase_next = phase_q;

		unique case (phase_q)
			PH_HDR0: begin
				emit_byte  = magic_first_q;
				crc_next   = crc16pf_pkg::crc_byte(crc16pf_pkg::CrcInit, magic_first_q);
				phase_next = PH_HDR1;
			end
			PH_HDR1: begin
				emit_byte  = magic_second_q;
				crc_next   = crc16pf_pkg::crc_byte(crc_q, magic_second_q);
				phase_next = PH_HDR2;
			end
			PH_HDR2: begin
				emit_byte  = packet_type_q;
				crc_next   = crc16pf_pkg::crc_byte(crc_q, packet_type_q);
				phase_next = PH_HDR3;
			end
			PH_HDR3: begin
				emit_byte  = len_eff[7:0];
				crc_next   = crc16pf_pkg::crc_byte(crc_q, len_eff[7:0]);
				phase_next = PH_HDR4;
			end
			PH_HDR4: begin
				emit_byte  = len_eff[15:8];
				crc_next   = crc16pf_pkg::crc_byte(crc_q, len_eff[15:8]);
				phase_next = PH_DATA;
			end
			PH_DATA: begin
				emit_byte = data_s1;
				crc_next  = crc16pf_pkg::crc_byte(crc_q, data_s1);
				if (count_inc >= {1'b0, len_eff}) begin
					count_next = '0;
					phase_next = PH_CRC_LO;
				end else begin
					count_next = count_inc[15:0];
					phase_next = PH_DATA;
					done       = 1'b1;
				end
			end
			PH_CRC_LO: begin
				emit_byte  = crc_q[7:0];
				phase_next = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				emit_byte  = crc_q[15:8];
				emit_end   = 1'b1;
				done       = 1'b1;
				crc_next   = crc16pf_pkg::CrcInit;
				phase_next = PH_HDR0;
			end
			default: begin
				phase_next = PH_HDR0;
			end
		endcase

		in_stall = valid_s1 && !(emit && done);
		in_take  = in_valid && !in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_first_q    <= '0;
			magic_second_q   <= '0;
			packet_type_q    <= '0;
			payload_length_q <= crc16pf_pkg::LengthReset;
		end else if (cfg_we) begin
			unique case (crc16pf_pkg::cfg_reg_t'(cfg_index))
				crc16pf_pkg::REG_MAGIC_FIRST:    magic_first_q    <= cfg_data[7:0];
				crc16pf_pkg::REG_MAGIC_SECOND:   magic_second_q   <= cfg_data[7:0];
				crc16pf_pkg::REG_PACKET_TYPE:    packet_type_q    <= cfg_data[7:0];
				crc16pf_pkg::REG_PAYLOAD_LENGTH: payload_length_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			data_s1      <= '0;
			phase_q      <= PH_HDR0;
			count_q      <= '0;
			crc_q        <= crc16pf_pkg::CrcInit;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			run_last_q   <= 1'b0;
			packet_end_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
				data_s1  <= payload_byte;
			end else if (emit && done) begin
				valid_s1 <= 1'b0;
			end

			if (emit) begin
				phase_q      <= phase_next;
				count_q      <= count_next;
				crc_q        <= crc_next;
				out_byte_q   <= emit_byte;
				run_last_q   <= done;
				packet_end_q <= emit_end;
			end

			if (advance) begin
				out_valid_q <= emit;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign run_last   = run_last_q;
	assign packet_end = packet_end_q;

endmodule

@@ tb/sv/crc16pf_frame_checker.sv @@
// Checker for the CRC-16 packet framer: watches the register port and both channels,
// predicts the framed byte stream and compares every accepted result byte.
// Depends on crc16pf_pkg for register indexes and CRC constants.
module crc16pf_frame_checker
	import crc16pf_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [7:0]               payload_byte,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [7:0]               out_byte,
	input  logic                     run_last,
	input  logic                     packet_end,
	output int                       mismatches,
	output int                       awaited,
	output int                       packets_closed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       tail;
	} framed_byte_t;

	framed_byte_t framed_q[$];

	logic [7:0]  hdr_first;
	logic [7:0]  hdr_second;
	logic [7:0]  hdr_type;
	logic [15:0] frame_len;
	logic [15:0] taken_count;
	logic [15:0] running_crc;

	function automatic logic [15:0] crc16_shift_in(input logic [15:0] crc,
			input logic [7:0] data);
		logic [15:0] r;
		logic        fb;
		r = crc;
		for (int k = 0; k < 8; k++) begin
			fb = r[0] ^ data[k];
			r  = r >> 1;
			if (fb) begin
				r = r ^ CrcPoly;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic queue_byte(input logic [7:0] data, input logic covered,
			input logic last, input logic tail);
		framed_byte_t fb;
		fb.data = data;
		fb.last = last;
		fb.tail = tail;
		framed_q.push_back(fb);
		if (covered) begin
			running_crc = crc16_shift_in(running_crc, data);
		end
	endtask

	task automatic frame_byte(input logic [7:0] data);
		logic [15:0] len;
		logic [15:0] crc_out;
		logic        closes;
		len    = (frame_len < LengthMinimum) ? LengthMinimum : frame_len;
		closes = (32'(taken_count) + 1) >= 32'(len);
		if (taken_count == 16'd0) begin
			running_crc = CrcInit;
			queue_byte(hdr_first, 1'b1, 1'b0, 1'b0);
			queue_byte(hdr_second, 1'b1, 1'b0, 1'b0);
			queue_byte(hdr_type, 1'b1, 1'b0, 1'b0);
			queue_byte(len[7:0], 1'b1, 1'b0, 1'b0);
			queue_byte(len[15:8], 1'b1, 1'b0, 1'b0);
		end
		queue_byte(data, 1'b1, !closes, 1'b0);
		taken_count = taken_count + 16'd1;
		if (closes) begin
			crc_out = running_crc;
			queue_byte(crc_out[7:0], 1'b0, 1'b0, 1'b0);
			queue_byte(crc_out[15:8], 1'b0, 1'b1, 1'b1);
			taken_count = 16'd0;
			running_crc = CrcInit;
			packets_closed++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		framed_byte_t want;
		if (!arst_n) begin
			framed_q.delete();
			hdr_first      = 8'h00;
			hdr_second     = 8'h00;
			hdr_type       = 8'h00;
			frame_len      = LengthReset;
			taken_count    = 16'd0;
			running_crc    = CrcInit;
			mismatches     = 0;
			packets_closed = 0;
			awaited <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (framed_q.size() == 0) begin
					report_mismatch("unexpected result byte", 16'(out_byte), 16'd0);
				end else begin
					want = framed_q.pop_front();
					if (out_byte !== want.data) begin
						report_mismatch("out_byte", 16'(out_byte), 16'(want.data));
					end
					if (run_last !== want.last) begin
						report_mismatch("run_last", 16'(run_last), 16'(want.last));
					end
					if (packet_end !== want.tail) begin
						report_mismatch("packet_end", 16'(packet_end), 16'(want.tail));
					end
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_MAGIC_FIRST: begin
						hdr_first = cfg_data[7:0];
					end
					REG_MAGIC_SECOND: begin
						hdr_second = cfg_data[7:0];
					end
					REG_PACKET_TYPE: begin
						hdr_type = cfg_data[7:0];
					end
					REG_PAYLOAD_LENGTH: begin
						frame_len = cfg_data[15:0];
					end
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall) begin
				frame_byte(payload_byte);
			end
			awaited <= framed_q.size();
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
// Top of the CRC-16 packet framer testbench: clock, reset, register writes and payload stimulus.
// Instantiates crc16_packet_framer_unit and crc16pf_frame_checker; uses crc16pf_pkg.
module tb_top;
	import crc16pf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit  = 400000;
	localparam int DrainHold   = 3;
	localparam int RandomItems = 360;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     cfg_we       = 1'b0;
	logic [CfgIndexWidth-1:0] cfg_index    = '0;
	logic [CfgDataWidth-1:0]  cfg_data     = '0;
	logic                     in_valid     = 1'b0;
	logic [7:0]               payload_byte = 8'h00;
	logic                     out_stall    = 1'b0;
	logic                     in_stall;
	logic                     out_valid;
	logic [7:0]               out_byte;
	logic                     run_last;
	logic                     packet_end;

	int mismatches;
	int awaited;
	int packets_closed;
	int send_idle     = 0;
	int recv_idle     = 0;
	int cycle_count   = 0;
	int items_sent    = 0;
	int setting_count = 0;

	crc16_packet_framer_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.payload_byte (payload_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.run_last     (run_last),
		.packet_end   (packet_end)
	);

	crc16pf_frame_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.payload_byte   (payload_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.run_last       (run_last),
		.packet_end     (packet_end),
		.mismatches     (mismatches),
		.awaited        (awaited),
		.packets_closed (packets_closed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("crc16_packet_framer_unit: mismatch");
			$finish;
		end
	end

	task automatic program_regs(input logic [15:0] first_v, input logic [15:0] second_v,
			input logic [15:0] type_v, input logic [15:0] length_v);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAGIC_FIRST;
		cfg_data  <= first_v;
		@(posedge clk);
		cfg_index <= REG_MAGIC_SECOND;
		cfg_data  <= second_v;
		@(posedge clk);
		cfg_index <= REG_PACKET_TYPE;
		cfg_data  <= type_v;
		@(posedge clk);
		cfg_index <= REG_PAYLOAD_LENGTH;
		cfg_data  <= length_v;
		@(posedge clk);
		cfg_we <= 1'b0;
		setting_count++;
	endtask

	task automatic send_bytes(input logic [7:0] stream[$]);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle) gap++;
		foreach (stream[i]) begin
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid     <= 1'b1;
			payload_byte <= stream[i];
			@(posedge clk);
			while (in_stall) @(posedge clk);
			items_sent++;
			gap = 0;
			while ($urandom_range(0, 99) < send_idle) gap++;
		end
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (DrainHold) @(posedge clk);
	endtask

	initial begin
		logic [7:0]  stream[$];
		logic [15:0] length_v;
		int          done;
		int          count;
		int          sel;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The reset header carries zero magic and type and a length of 46080.
		stream = '{8'h00, 8'hFF, 8'hA5};
		send_bytes(stream);
		wait_drained();
		// A zero length acts as two, so the open packet closes on the next byte.
		program_regs(16'h00FF, 16'hFF00, 16'h12A5, 16'h0000);
		stream = '{8'h3C, 8'hFF, 8'h00};
		send_bytes(stream);
		wait_drained();
		program_regs(16'hAB00, 16'h00FF, 16'hFFFF, 16'h0001);
		stream = '{8'h81, 8'h7E};
		send_bytes(stream);
		wait_drained();
		program_regs(16'h00A5, 16'h005A, 16'h0001, 16'h0004);
		stream = '{8'h11, 8'h22};
		send_bytes(stream);
		wait_drained();
		// New header values only show up in the next packet.
		program_regs(16'h00C3, 16'h003C, 16'h0080, 16'h0004);
		stream = '{8'h33, 8'h44, 8'h55};
		send_bytes(stream);
		wait_drained();
		program_regs(16'h00C3, 16'h003C, 16'h0080, 16'hFFFF);
		stream = '{8'h66, 8'h77};
		send_bytes(stream);
		wait_drained();
		program_regs(16'h00C3, 16'h003C, 16'h0080, 16'h0003);
		stream = '{8'h88};
		send_bytes(stream);
		wait_drained();
		program_regs(16'h00C3, 16'h003C, 16'h0080, 16'hFFFF);
		stream = '{8'h99};
		send_bytes(stream);
		wait_drained();
		program_regs(16'h00C3, 16'h003C, 16'h0080, 16'h0002);
		stream = '{8'hAA};
		send_bytes(stream);
		wait_drained();

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle = 9;
					recv_idle = 59;
				end
				1: begin
					send_idle = 59;
					recv_idle = 9;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			done = 0;
			while (done < RandomItems / 3) begin
				count = $urandom_range(8, 30);
				if (count > RandomItems / 3 - done) begin
					count = RandomItems / 3 - done;
				end
				sel = $urandom_range(0, 19);
				case (sel)
					0: length_v = 16'h0000;
					1: length_v = 16'h0001;
					2: length_v = 16'hFFFF;
					3: length_v = 16'($urandom_range(11, 200));
					default: length_v = 16'($urandom_range(2, 10));
				endcase
				wait_drained();
				program_regs(16'($urandom), 16'($urandom), 16'($urandom), length_v);
				stream.delete();
				repeat (count) stream.push_back(8'($urandom));
				send_bytes(stream);
				done += count;
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Framed %0d payload bytes into %0d closed packets under %0d register settings,",
			items_sent, packets_closed, setting_count);
		$display("with receiver-heavy, sender-heavy and stall-free phases.");
		if (mismatches == 0) begin
			$display("crc16_packet_framer_unit: match");
		end else begin
			$display("crc16_packet_framer_unit: mismatch");
		end
		$finish;
	end

endmodule
